>>> hw/rtl/erm_pkg.sv
package erm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int CORDIC_STAGES = 30;
    localparam int LANES         = 3;
    localparam int CW            = 34;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURN32 [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } lane_t;

endpackage

>>> hw/rtl/euler_rotation_matrix.sv
// Euler XYZ rotation matrix from three binary angles (full turn = 2^ANGLE_BITS).
// Fully pipelined: one transaction per clock is accepted and one result per
// clock is delivered. On the path from the accepting edge to m_valid, the
// angle-folding register is loaded at that edge, then come 30 CORDIC cells (one
// per iteration, three angles side by side), then four stages for rounding, the
// pair products, the triple products and the final sums with saturation to
// +-2^FRAC_BITS. A low m_ready while m_valid is high freezes the whole pipeline,
// and s_ready drops in the same cycle. Outputs are Q1.FRAC_BITS two's complement.
module euler_rotation_matrix #(
    parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = erm_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ANGLE_BITS-1:0]         s_angle_x,
    input  logic [ANGLE_BITS-1:0]         s_angle_y,
    input  logic [ANGLE_BITS-1:0]         s_angle_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [FRAC_BITS+1:0]   m00,
    output logic signed [FRAC_BITS+1:0]   m01,
    output logic signed [FRAC_BITS+1:0]   m02,
    output logic signed [FRAC_BITS+1:0]   m10,
    output logic signed [FRAC_BITS+1:0]   m11,
    output logic signed [FRAC_BITS+1:0]   m12,
    output logic signed [FRAC_BITS+1:0]   m20,
    output logic signed [FRAC_BITS+1:0]   m21,
    output logic signed [FRAC_BITS+1:0]   m22
);

    localparam int NS = erm_pkg::CORDIC_STAGES;
    localparam int NL = erm_pkg::LANES;

    logic en;

    logic                     in_valid_reg;
    erm_pkg::lane_t [NL-1:0]  in_lane_reg;
    erm_pkg::lane_t [NL-1:0]  in_lane_next;

    logic                     chain_valid [NS+1];
    erm_pkg::lane_t [NL-1:0]  chain_lane  [NS+1];

    function automatic erm_pkg::lane_t fold(input logic [ANGLE_BITS-1:0] angle);
        logic [31:0]    a32;
        erm_pkg::lane_t l;
        a32    = 32'(angle) << (32 - ANGLE_BITS);
        l.flip = a32[31] ^ a32[30];
        a32[31] = a32[31] ^ l.flip;
        l.x    = erm_pkg::CORDIC_GAIN_Q30;
        l.y    = '0;
        l.z    = erm_pkg::CW'($signed(a32));
        return l;
    endfunction

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        in_lane_next[0] = fold(s_angle_x);
        in_lane_next[1] = fold(s_angle_y);
        in_lane_next[2] = fold(s_angle_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_lane_reg <= in_lane_next;
        end
    end

    assign chain_valid[0] = in_valid_reg;
    assign chain_lane[0]  = in_lane_reg;

    for (genvar i = 0; i < NS; i++) begin : g_cell
        erm_cordic_cell #(
            .STAGE(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (chain_valid[i]),
            .lane_in   (chain_lane[i]),
            .valid_out (chain_valid[i+1]),
            .lane_out  (chain_lane[i+1])
        );
    end

    erm_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .valid_in (chain_valid[NS]),
        .lane_in  (chain_lane[NS]),
        .m_valid  (m_valid),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22)
    );

endmodule

>>> hw/rtl/erm_cordic_cell.sv
module erm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  valid_in,
    input  erm_pkg::lane_t [erm_pkg::LANES-1:0]   lane_in,
    output logic                                  valid_out,
    output erm_pkg::lane_t [erm_pkg::LANES-1:0]   lane_out
);

    localparam logic signed [erm_pkg::CW-1:0] ATAN =
        $signed({2'b00, erm_pkg::ATAN_TURN32[STAGE]});

    logic                                valid_reg;
    erm_pkg::lane_t [erm_pkg::LANES-1:0] lane_reg;
    erm_pkg::lane_t [erm_pkg::LANES-1:0] lane_next;

    always_comb begin
        logic signed [erm_pkg::CW-1:0] dx;
        logic signed [erm_pkg::CW-1:0] dy;
        lane_next = lane_in;
        for (int k = 0; k < erm_pkg::LANES; k++) begin
            dx = $signed(lane_in[k].y) >>> STAGE;
            dy = $signed(lane_in[k].x) >>> STAGE;
            if (!lane_in[k].z[erm_pkg::CW-1]) begin
                lane_next[k].x = lane_in[k].x - dx;
                lane_next[k].y = lane_in[k].y + dy;
                lane_next[k].z = lane_in[k].z - ATAN;
            end else begin
                lane_next[k].x = lane_in[k].x + dx;
                lane_next[k].y = lane_in[k].y - dy;
                lane_next[k].z = lane_in[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign valid_out = valid_reg;
    assign lane_out  = lane_reg;

endmodule

>>> hw/rtl/erm_matrix.sv
module erm_matrix #(
    parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  erm_pkg::lane_t [erm_pkg::LANES-1:0]  lane_in,
    output logic                                 m_valid,
    output logic signed [FRAC_BITS+1:0]          m00,
    output logic signed [FRAC_BITS+1:0]          m01,
    output logic signed [FRAC_BITS+1:0]          m02,
    output logic signed [FRAC_BITS+1:0]          m10,
    output logic signed [FRAC_BITS+1:0]          m11,
    output logic signed [FRAC_BITS+1:0]          m12,
    output logic signed [FRAC_BITS+1:0]          m20,
    output logic signed [FRAC_BITS+1:0]          m21,
    output logic signed [FRAC_BITS+1:0]          m22
);

    localparam int W  = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0]    ONE    = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0]    HALF_Q = (36'sd1 <<< SH) >>> 1;
    localparam logic signed [2*W-1:0] HALF_P = (2*W)'(1) <<< (FRAC_BITS - 1);

    typedef logic signed [W-1:0] val_t;

    function automatic val_t sat(input logic signed [35:0] v);
        val_t r;
        if (v > ONE) begin
            r = ONE[W-1:0];
        end else if (v < -ONE) begin
            r = val_t'(-ONE);
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic val_t from_q30(input logic flip, input logic signed [33:0] v);
        logic signed [35:0] t;
        t = flip ? -36'(v) : 36'(v);
        t = (t + HALF_Q) >>> SH;
        return sat(t);
    endfunction

    function automatic val_t mulr(input val_t a, input val_t b);
        logic signed [2*W-1:0] p;
        p = a * b;
        p = (p + HALF_P) >>> FRAC_BITS;
        return p[W-1:0];
    endfunction

    function automatic val_t sum2(input val_t a, input val_t b, input logic neg_a,
                                  input logic neg_b);
        logic signed [W:0] ea;
        logic signed [W:0] eb;
        ea = neg_a ? -(W+1)'(a) : (W+1)'(a);
        eb = neg_b ? -(W+1)'(b) : (W+1)'(b);
        return sat(36'(ea + eb));
    endfunction

    // sine/cosine stage: lane 0 is x, 1 is y, 2 is z
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    val_t sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;

    // first products
    val_t cycz_reg, czsx_reg, cxsz_reg, cxcz_reg, cysz_reg;
    val_t sxsy_reg, sxsz_reg, cxsy_reg, cysx_reg, cxcy_reg, sy1_reg, sz1_reg;

    // triple products and carried terms
    val_t t01_reg, t02_reg, t11_reg, t12_reg;
    val_t cycz2_reg, czsx2_reg, cxsz2_reg, cxcz2_reg, cysz2_reg;
    val_t sxsz2_reg, cysx2_reg, cxcy2_reg, sy2_reg;

    val_t m00_reg, m01_reg, m02_reg, m10_reg, m11_reg, m12_reg;
    val_t m20_reg, m21_reg, m22_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= valid_in;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= from_q30(lane_in[0].flip, lane_in[0].x);
            sx_reg <= from_q30(lane_in[0].flip, lane_in[0].y);
            cy_reg <= from_q30(lane_in[1].flip, lane_in[1].x);
            sy_reg <= from_q30(lane_in[1].flip, lane_in[1].y);
            cz_reg <= from_q30(lane_in[2].flip, lane_in[2].x);
            sz_reg <= from_q30(lane_in[2].flip, lane_in[2].y);

            cycz_reg <= mulr(cy_reg, cz_reg);
            czsx_reg <= mulr(cz_reg, sx_reg);
            cxsz_reg <= mulr(cx_reg, sz_reg);
            cxcz_reg <= mulr(cx_reg, cz_reg);
            cysz_reg <= mulr(cy_reg, sz_reg);
            sxsy_reg <= mulr(sx_reg, sy_reg);
            sxsz_reg <= mulr(sx_reg, sz_reg);
            cxsy_reg <= mulr(cx_reg, sy_reg);
            cysx_reg <= mulr(cy_reg, sx_reg);
            cxcy_reg <= mulr(cx_reg, cy_reg);
            sy1_reg  <= sy_reg;
            sz1_reg  <= sz_reg;

            t01_reg   <= mulr(czsx_reg, sy1_reg);
            t02_reg   <= mulr(cxcz_reg, sy1_reg);
            t11_reg   <= mulr(sxsy_reg, sz1_reg);
            t12_reg   <= mulr(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            czsx2_reg <= czsx_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            cysz2_reg <= cysz_reg;
            sxsz2_reg <= sxsz_reg;
            cysx2_reg <= cysx_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg   <= sy1_reg;

            m00_reg <= cycz2_reg;
            m01_reg <= sum2(t01_reg, cxsz2_reg, 1'b0, 1'b0);
            m02_reg <= sum2(t02_reg, sxsz2_reg, 1'b1, 1'b0);
            m10_reg <= sum2(cysz2_reg, '0, 1'b1, 1'b0);
            m11_reg <= sum2(cxcz2_reg, t11_reg, 1'b0, 1'b1);
            m12_reg <= sum2(czsx2_reg, t12_reg, 1'b0, 1'b0);
            m20_reg <= sy2_reg;
            m21_reg <= sum2(cysx2_reg, '0, 1'b1, 1'b0);
            m22_reg <= cxcy2_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m00 = m00_reg;
    assign m01 = m01_reg;
    assign m02 = m02_reg;
    assign m10 = m10_reg;
    assign m11 = m11_reg;
    assign m12 = m12_reg;
    assign m20 = m20_reg;
    assign m21 = m21_reg;
    assign m22 = m22_reg;

endmodule

>>> hw/rtl/erm_checker.sv
module erm_checker #(
    parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [FRAC_BITS+1:0]  m00,
    input logic signed [FRAC_BITS+1:0]  m01,
    input logic signed [FRAC_BITS+1:0]  m02,
    input logic signed [FRAC_BITS+1:0]  m10,
    input logic signed [FRAC_BITS+1:0]  m11,
    input logic signed [FRAC_BITS+1:0]  m12,
    input logic signed [FRAC_BITS+1:0]  m20,
    input logic signed [FRAC_BITS+1:0]  m21,
    input logic signed [FRAC_BITS+1:0]  m22
);

    localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) <<< FRAC_BITS;

    function automatic logic in_rng(input logic signed [FRAC_BITS+1:0] v);
        return (v <= ONE) && (v >= -ONE);
    endfunction

    logic [9*(FRAC_BITS+2)-1:0] m_all;
    assign m_all = {m00, m01, m02, m10, m11, m12, m20, m21, m22};

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_all))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready) || !s_valid && (s_ready == (!m_valid || m_ready)))
        else $error("input ready does not follow output stall");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> in_rng(m00) && in_rng(m01) && in_rng(m02) && in_rng(m10)
                    && in_rng(m11) && in_rng(m12) && in_rng(m20) && in_rng(m21)
                    && in_rng(m22))
        else $error("matrix entry out of range");

endmodule

bind euler_rotation_matrix erm_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_erm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m00     (m00),
    .m01     (m01),
    .m02     (m02),
    .m10     (m10),
    .m11     (m11),
    .m12     (m12),
    .m20     (m20),
    .m21     (m21),
    .m22     (m22)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int AW = erm_pkg::ANGLE_BITS_DEF;
    localparam int FW = erm_pkg::FRAC_BITS_DEF;

    localparam int N_DIRECTED = 18;
    localparam int N_RANDOM   = 930;
    localparam int PHASE_LEN  = 310;
    localparam int DRAIN_WAIT = 60;
    localparam int CYCLE_LIMIT = 200000;

    // per phase: sender idle and receiver stall, in percent
    localparam int IDLE_PCT  [3] = '{8, 73, 0};
    localparam int STALL_PCT [3] = '{73, 8, 0};

    localparam longint UNIT      = 64'sd16384;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint ARCTAN_STEP [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef logic [8:0][15:0] matrix_t;

    typedef struct {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        int          phase;
        logic        drain;
    } angle_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [AW-1:0] s_angle_x = '0;
    logic [AW-1:0] s_angle_y = '0;
    logic [AW-1:0] s_angle_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [FW+1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    angle_item_t angle_q [$];
    matrix_t     matrix_q [$];
    int unsigned accepted_n = 0;
    int unsigned compared_n = 0;
    int unsigned err_count = 0;
    int          recv_stall_pct = 73;
    int unsigned cycle_n = 0;

    string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    euler_rotation_matrix dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_angle_x (s_angle_x),
        .s_angle_y (s_angle_y),
        .s_angle_z (s_angle_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22)
    );

    function automatic longint clip_unit(input longint v);
        if (v > UNIT) begin
            return UNIT;
        end
        if (v < -UNIT) begin
            return -UNIT;
        end
        return v;
    endfunction

    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + 64'sd8192) >>> 14;
    endfunction

    function automatic void sin_cos_q14(input logic [15:0] ang, output longint sn,
                                        output longint cs);
        logic [31:0] a32;
        logic        flip;
        longint      x, y, z, dx, dy;
        a32 = {ang, 16'h0000};
        flip = a32[31] ^ a32[30];
        if (flip) begin
            a32 = a32 - 32'h8000_0000;
        end
        z = {{32{a32[31]}}, a32};
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clip_unit((x + 64'sd32768) >>> 16);
        sn = clip_unit((y + 64'sd32768) >>> 16);
    endfunction

    function automatic matrix_t rotation_matrix(input logic [15:0] ax, input logic [15:0] ay,
                                                input logic [15:0] az);
        longint  sx, cx, sy, cy, sz, cz;
        longint  e [9];
        matrix_t m;
        sin_cos_q14(ax, sx, cx);
        sin_cos_q14(ay, sy, cy);
        sin_cos_q14(az, sz, cz);
        e[0] = round_mul(cy, cz);
        e[1] = round_mul(round_mul(cz, sx), sy) + round_mul(cx, sz);
        e[2] = -round_mul(round_mul(cx, cz), sy) + round_mul(sx, sz);
        e[3] = -round_mul(cy, sz);
        e[4] = round_mul(cx, cz) - round_mul(round_mul(sx, sy), sz);
        e[5] = round_mul(cz, sx) + round_mul(round_mul(cx, sy), sz);
        e[6] = sy;
        e[7] = -round_mul(cy, sx);
        e[8] = round_mul(cx, cy);
        for (int k = 0; k < 9; k++) begin
            e[k] = clip_unit(e[k]);
            m[k] = e[k][15:0];
        end
        return m;
    endfunction

    // angles biased toward quadrant edges and octants, where folding and saturation bite
    function automatic logic [15:0] pick_angle();
        logic [15:0] a;
        case ($urandom_range(3))
            0: a = 16'($urandom);
            1: a = {2'($urandom), 14'h0000} + 16'($urandom_range(6)) - 16'd3;
            2: a = {3'($urandom), 13'h0000} + 16'($urandom_range(64)) - 16'd32;
            default: a = {4'($urandom), ($urandom_range(1) != 0) ? 12'hFFF : 12'h000};
        endcase
        return a;
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("euler_rotation_matrix: mismatch");
            $finish;
        end
    end

    // driver: predicts on acceptance, then presents the next triple
    always @(posedge aclk) begin : drive_proc
        angle_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                matrix_q.push_back(rotation_matrix(s_angle_x, s_angle_y, s_angle_z));
                accepted_n <= accepted_n + 1;
            end
            if (!s_valid || s_ready) begin
                if (angle_q.size() != 0 &&
                    (!angle_q[0].drain || (!s_valid && accepted_n == compared_n)) &&
                    $urandom_range(99) >= IDLE_PCT[angle_q[0].phase]) begin
                    nxt = angle_q.pop_front();
                    s_valid <= 1'b1;
                    s_angle_x <= nxt.ax;
                    s_angle_y <= nxt.ay;
                    s_angle_z <= nxt.az;
                    recv_stall_pct <= STALL_PCT[nxt.phase];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transaction against the oldest predicted matrix
    always @(posedge aclk) begin : monitor_proc
        matrix_t got;
        matrix_t want;
        int      bad;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                if (compared_n >= accepted_n) begin
                    err_count <= err_count + 1;
                    $display("%0t: unexpected result transaction", $time);
                end else begin
                    want = matrix_q.pop_front();
                    compared_n <= compared_n + 1;
                    bad = 0;
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k]) begin
                            bad = bad + 1;
                            $display("%0t: %s expected %0d got %0d", $time, entry_name[k],
                                     $signed(want[k]), $signed(got[k]));
                        end
                    end
                    if (bad != 0) begin
                        err_count <= err_count + 1;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        logic [47:0] directed [N_DIRECTED];
        angle_item_t it;
        directed = '{
            48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h4000_0000_0000,
            48'h0000_4000_0000, 48'h0000_0000_4000, 48'h8000_8000_8000,
            48'hC000_C000_C000, 48'h3FFF_7FFF_BFFF, 48'h4001_8001_C001,
            48'h2000_2000_2000, 48'h6000_A000_E000, 48'h4000_4000_4000,
            48'h0001_0002_0003, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555,
            48'hC000_4000_8000, 48'h1555_2AAA_E38E, 48'hFFFF_0000_8000
        };
        for (int i = 0; i < N_DIRECTED; i++) begin
            it.ax = directed[i][47:32];
            it.ay = directed[i][31:16];
            it.az = directed[i][15:0];
            it.phase = 0;
            it.drain = 1'b0;
            angle_q.push_back(it);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            it.ax = pick_angle();
            it.ay = pick_angle();
            it.az = pick_angle();
            it.phase = (i / PHASE_LEN > 2) ? 2 : i / PHASE_LEN;
            it.drain = (i == PHASE_LEN / 2 || i == PHASE_LEN || i == 2 * PHASE_LEN);
            angle_q.push_back(it);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (angle_q.size() != 0 || s_valid || compared_n != accepted_n) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_count == 0 && compared_n == accepted_n) begin
            $display("euler_rotation_matrix: match");
        end else begin
            $display("euler_rotation_matrix: mismatch");
        end
        $finish;
    end

endmodule
